>>> rtl/trl_pkg.sv
package trl_pkg;

  // Fixed field widths
  localparam int RNG_W  = 16;           // range inputs
  localparam int ANC_W  = 16;           // anchor coordinates
  localparam int MIN_W  = 32;           // minimum determinant register
  localparam int SQ_W   = 32;           // square of a range
  localparam int A_W    = 18;           // equation coefficients a1, b1, a2, b2
  localparam int K_W    = 34;           // anchor square sums
  localparam int C_W    = 35;           // right-hand sides c1, c2
  localparam int P_W    = 53;           // c * a and c * b products
  localparam int N_W    = 54;           // numerators nx, ny
  localparam int NM_W   = 54;           // numerator magnitude
  localparam int M_W    = 36;           // a * b products
  localparam int D_W    = 37;           // determinant
  localparam int DM_W   = 37;           // determinant magnitude
  localparam int XW     = 64;           // compare width for shifted divisor
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes
  localparam logic [2:0] REG_AX  = 3'd0;
  localparam logic [2:0] REG_AY  = 3'd1;
  localparam logic [2:0] REG_BX  = 3'd2;
  localparam logic [2:0] REG_BY  = 3'd3;
  localparam logic [2:0] REG_CX  = 3'd4;
  localparam logic [2:0] REG_CY  = 3'd5;
  localparam logic [2:0] REG_MIN = 3'd6;

  // Values derived from the anchor registers
  typedef struct packed {
    logic signed [A_W-1:0] a1;
    logic signed [A_W-1:0] b1;
    logic signed [A_W-1:0] a2;
    logic signed [A_W-1:0] b2;
    logic signed [K_W-1:0] k1;
    logic signed [K_W-1:0] k2;
    logic [DM_W-1:0]       dmag;
    logic                  dneg;
    logic                  ok;
  } cfg_t;

  // Sideband that travels with each transaction through the divider
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic solved;
  } side_t;

endpackage

>>> rtl/trl_if.sv
interface trl_in_if;
  logic                          valid;
  logic                          ready;
  logic [trl_pkg::RNG_W-1:0]     range_a;
  logic [trl_pkg::RNG_W-1:0]     range_b;
  logic [trl_pkg::RNG_W-1:0]     range_c;
  modport source (output valid, range_a, range_b, range_c, input ready);
  modport sink (input valid, range_a, range_b, range_c, output ready);
endinterface

interface trl_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic                         solved;
  logic                         clipped;
  modport source (output valid, pos_x, pos_y, solved, clipped, input ready);
  modport sink (input valid, pos_x, pos_y, solved, clipped, output ready);
endinterface

>>> rtl/trl_cfg.sv
module trl_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [trl_pkg::ADDR_W-1:0]   paddr,
  input  logic [trl_pkg::DATA_W-1:0]   pwdata,
  output logic [trl_pkg::DATA_W-1:0]   prdata,
  output trl_pkg::cfg_t                cfg
);

  logic signed [trl_pkg::ANC_W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [trl_pkg::MIN_W-1:0]        mindet_r;
  logic [2:0]                       idx;
  logic                             wr;

  logic signed [trl_pkg::A_W-1:0]   a1_r, b1_r, a2_r, b2_r;
  logic signed [trl_pkg::K_W-1:0]   k1_r, k2_r;
  logic signed [trl_pkg::M_W-1:0]   m1_r, m2_r;
  logic signed [trl_pkg::D_W-1:0]   det_r;
  logic [trl_pkg::DM_W-1:0]         dmag_r;
  logic                             dneg_r, ok_r;

  logic signed [trl_pkg::SQ_W-1:0]  sax, say, sbx, sby, scx, scy;
  logic signed [trl_pkg::A_W-1:0]   a1_nxt, b1_nxt, a2_nxt, b2_nxt;
  logic signed [trl_pkg::K_W-1:0]   k1_nxt, k2_nxt;
  logic signed [trl_pkg::D_W-1:0]   det_nxt;
  logic [trl_pkg::DM_W-1:0]         dmag_nxt;

  assign idx = paddr[4:2];
  assign wr  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r     <= -16'sd90;
      ay_r     <= 16'sd0;
      bx_r     <= 16'sd90;
      by_r     <= 16'sd0;
      cx_r     <= 16'sd0;
      cy_r     <= 16'sd450;
      mindet_r <= 32'd1;
    end else if (wr) begin
      case (idx)
        trl_pkg::REG_AX:  ax_r     <= pwdata[15:0];
        trl_pkg::REG_AY:  ay_r     <= pwdata[15:0];
        trl_pkg::REG_BX:  bx_r     <= pwdata[15:0];
        trl_pkg::REG_BY:  by_r     <= pwdata[15:0];
        trl_pkg::REG_CX:  cx_r     <= pwdata[15:0];
        trl_pkg::REG_CY:  cy_r     <= pwdata[15:0];
        trl_pkg::REG_MIN: mindet_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      trl_pkg::REG_AX:  prdata = {16'd0, ax_r};
      trl_pkg::REG_AY:  prdata = {16'd0, ay_r};
      trl_pkg::REG_BX:  prdata = {16'd0, bx_r};
      trl_pkg::REG_BY:  prdata = {16'd0, by_r};
      trl_pkg::REG_CX:  prdata = {16'd0, cx_r};
      trl_pkg::REG_CY:  prdata = {16'd0, cy_r};
      trl_pkg::REG_MIN: prdata = mindet_r;
      default:          prdata = '0;
    endcase
  end

  // Coefficients, anchor square sums, determinant and its magnitude
  always_comb begin
    sax    = trl_pkg::SQ_W'(ax_r * ax_r);
    say    = trl_pkg::SQ_W'(ay_r * ay_r);
    sbx    = trl_pkg::SQ_W'(bx_r * bx_r);
    sby    = trl_pkg::SQ_W'(by_r * by_r);
    scx    = trl_pkg::SQ_W'(cx_r * cx_r);
    scy    = trl_pkg::SQ_W'(cy_r * cy_r);
    a1_nxt = (trl_pkg::A_W'(bx_r) - trl_pkg::A_W'(ax_r)) <<< 1;
    b1_nxt = (trl_pkg::A_W'(by_r) - trl_pkg::A_W'(ay_r)) <<< 1;
    a2_nxt = (trl_pkg::A_W'(cx_r) - trl_pkg::A_W'(bx_r)) <<< 1;
    b2_nxt = (trl_pkg::A_W'(cy_r) - trl_pkg::A_W'(by_r)) <<< 1;
    k1_nxt = trl_pkg::K_W'(sbx) + trl_pkg::K_W'(sby)
           - trl_pkg::K_W'(sax) - trl_pkg::K_W'(say);
    k2_nxt = trl_pkg::K_W'(scx) + trl_pkg::K_W'(scy)
           - trl_pkg::K_W'(sbx) - trl_pkg::K_W'(sby);
    det_nxt  = trl_pkg::D_W'(m1_r) - trl_pkg::D_W'(m2_r);
    dmag_nxt = det_r[trl_pkg::D_W-1] ? trl_pkg::DM_W'(-det_r) : trl_pkg::DM_W'(det_r);
  end

  // Derived values, registered in turn: coefficients, products, determinant, then magnitude and flags
  always_ff @(posedge clk) begin
    a1_r   <= a1_nxt;
    b1_r   <= b1_nxt;
    a2_r   <= a2_nxt;
    b2_r   <= b2_nxt;
    k1_r   <= k1_nxt;
    k2_r   <= k2_nxt;
    m1_r   <= trl_pkg::M_W'(a1_r * b2_r);
    m2_r   <= trl_pkg::M_W'(b1_r * a2_r);
    det_r  <= det_nxt;
    dmag_r <= dmag_nxt;
    dneg_r <= det_r[trl_pkg::D_W-1];
    ok_r   <= (det_r != '0) && (dmag_nxt >= trl_pkg::DM_W'(mindet_r));
  end

  assign cfg = '{a1: a1_r, b1: b1_r, a2: a2_r, b2: b2_r, k1: k1_r, k2: k2_r,
                 dmag: dmag_r, dneg: dneg_r, ok: ok_r};

endmodule

>>> rtl/trl_cell.sv
module trl_cell #(
  parameter int COORD_BITS = 16,
  parameter int SHIFT      = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  output logic                        adv_o,
  input  logic                        adv_i,
  input  trl_pkg::side_t              side_i,
  input  logic [trl_pkg::NM_W-1:0]    rx_i,
  input  logic [trl_pkg::NM_W-1:0]    ry_i,
  input  logic [COORD_BITS-1:0]       qx_i,
  input  logic [COORD_BITS-1:0]       qy_i,
  input  logic [trl_pkg::DM_W-1:0]    dmag,
  output logic                        vld_o,
  output trl_pkg::side_t              side_o,
  output logic [trl_pkg::NM_W-1:0]    rx_o,
  output logic [trl_pkg::NM_W-1:0]    ry_o,
  output logic [COORD_BITS-1:0]       qx_o,
  output logic [COORD_BITS-1:0]       qy_o
);

  logic                         vld_r;
  trl_pkg::side_t               side_r;
  logic [trl_pkg::NM_W-1:0]     rx_r, ry_r, rx_nxt, ry_nxt;
  logic [COORD_BITS-1:0]        qx_r, qy_r, qx_nxt, qy_nxt;
  logic [trl_pkg::XW-1:0]       dsh;
  logic                         gex, gey;

  // One restoring step per lane: try subtracting the shifted divisor
  always_comb begin
    dsh    = trl_pkg::XW'(dmag) << SHIFT;
    gex    = trl_pkg::XW'(rx_i) >= dsh;
    gey    = trl_pkg::XW'(ry_i) >= dsh;
    rx_nxt = gex ? trl_pkg::NM_W'(trl_pkg::XW'(rx_i) - dsh) : rx_i;
    ry_nxt = gey ? trl_pkg::NM_W'(trl_pkg::XW'(ry_i) - dsh) : ry_i;
    qx_nxt = qx_i | (gex ? (COORD_BITS'(1) << SHIFT) : '0);
    qy_nxt = qy_i | (gey ? (COORD_BITS'(1) << SHIFT) : '0);
  end

  assign adv_o = !vld_r || adv_i;

  // Advance when this cell is empty or the next cell can take our contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && vld_i) begin
      side_r <= side_i;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign rx_o   = rx_r;
  assign ry_o   = ry_r;
  assign qx_o   = qx_r;
  assign qy_o   = qy_r;

endmodule

>>> rtl/three_anchor_trilateration.sv
// Throughput: one transaction per cycle while the output is not stalled; five front
// stages, then one divider cell per quotient bit (both coordinates in parallel lanes),
// then the output register. Anchor-derived values settle through trl_cfg registers:
// coefficients and sums, then products, determinant, then magnitude, sign and ok flag.
// Reset (rst_n low, synchronous) empties the pipeline and restores register defaults.
module three_anchor_trilateration #(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  trl_in_if.sink                      in_ch,
  trl_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trl_pkg::ADDR_W-1:0]  paddr,
  input  logic [trl_pkg::DATA_W-1:0]  pwdata,
  output logic [trl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int NF = 5;

  trl_pkg::cfg_t cfg;

  trl_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
  );
  assign pready = 1'b1;

  // Front pipeline control
  logic [NF-1:0] fv_r;
  logic [NF-1:0] fadv;
  logic          div_adv;

  always_comb begin
    fadv[NF-1] = !fv_r[NF-1] || div_adv;
    for (int j = NF - 2; j >= 0; j--) begin
      fadv[j] = !fv_r[j] || fadv[j+1];
    end
  end
  assign in_ch.ready = fadv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      if (fadv[0]) fv_r[0] <= in_ch.valid;
      for (int j = 1; j < NF; j++) begin
        if (fadv[j]) fv_r[j] <= fv_r[j-1];
      end
    end
  end

  // Stage 1: range squares
  logic [trl_pkg::SQ_W-1:0] sqa_r, sqb_r, sqc_r;
  always_ff @(posedge clk) begin
    if (fadv[0] && in_ch.valid) begin
      sqa_r <= trl_pkg::SQ_W'(in_ch.range_a * in_ch.range_a);
      sqb_r <= trl_pkg::SQ_W'(in_ch.range_b * in_ch.range_b);
      sqc_r <= trl_pkg::SQ_W'(in_ch.range_c * in_ch.range_c);
    end
  end

  // Stage 2: right-hand sides
  logic signed [trl_pkg::C_W-1:0] c1_r, c2_r;
  always_ff @(posedge clk) begin
    if (fadv[1] && fv_r[0]) begin
      c1_r <= $signed(trl_pkg::C_W'(sqa_r)) - $signed(trl_pkg::C_W'(sqb_r))
            + trl_pkg::C_W'(cfg.k1);
      c2_r <= $signed(trl_pkg::C_W'(sqb_r)) - $signed(trl_pkg::C_W'(sqc_r))
            + trl_pkg::C_W'(cfg.k2);
    end
  end

  // Stage 3: numerator products
  logic signed [trl_pkg::P_W-1:0] px1_r, px2_r, py1_r, py2_r;
  always_ff @(posedge clk) begin
    if (fadv[2] && fv_r[1]) begin
      px1_r <= trl_pkg::P_W'(c1_r * cfg.b2);
      px2_r <= trl_pkg::P_W'(c2_r * cfg.b1);
      py1_r <= trl_pkg::P_W'(c2_r * cfg.a1);
      py2_r <= trl_pkg::P_W'(c1_r * cfg.a2);
    end
  end

  // Stage 4: numerators
  logic signed [trl_pkg::N_W-1:0] nx_r, ny_r;
  always_ff @(posedge clk) begin
    if (fadv[3] && fv_r[2]) begin
      nx_r <= trl_pkg::N_W'(px1_r) - trl_pkg::N_W'(px2_r);
      ny_r <= trl_pkg::N_W'(py1_r) - trl_pkg::N_W'(py2_r);
    end
  end

  // Stage 5: magnitudes, signs and range check of the quotient
  logic [trl_pkg::NM_W-1:0] nmx, nmy, rx0_r, ry0_r;
  logic [trl_pkg::XW-1:0]   dlim;
  trl_pkg::side_t           side0_r;
  always_comb begin
    nmx  = nx_r[trl_pkg::N_W-1] ? trl_pkg::NM_W'(-nx_r) : trl_pkg::NM_W'(nx_r);
    nmy  = ny_r[trl_pkg::N_W-1] ? trl_pkg::NM_W'(-ny_r) : trl_pkg::NM_W'(ny_r);
    dlim = trl_pkg::XW'(cfg.dmag) << COORD_BITS;
  end
  always_ff @(posedge clk) begin
    if (fadv[4] && fv_r[3]) begin
      rx0_r          <= nmx;
      ry0_r          <= nmy;
      side0_r.neg_x  <= nx_r[trl_pkg::N_W-1] ^ cfg.dneg;
      side0_r.neg_y  <= ny_r[trl_pkg::N_W-1] ^ cfg.dneg;
      side0_r.ovf_x  <= trl_pkg::XW'(nmx) >= dlim;
      side0_r.ovf_y  <= trl_pkg::XW'(nmy) >= dlim;
      side0_r.solved <= cfg.ok;
    end
  end

  // Divider chain: cell i settles quotient bit COORD_BITS-1-i
  logic                     cv   [COORD_BITS+1];
  logic                     cadv [COORD_BITS+1];
  trl_pkg::side_t           cs   [COORD_BITS+1];
  logic [trl_pkg::NM_W-1:0] crx  [COORD_BITS+1];
  logic [trl_pkg::NM_W-1:0] cry  [COORD_BITS+1];
  logic [COORD_BITS-1:0]    cqx  [COORD_BITS+1];
  logic [COORD_BITS-1:0]    cqy  [COORD_BITS+1];
  logic                     out_adv;

  assign cv[0]  = fv_r[NF-1];
  assign cs[0]  = side0_r;
  assign crx[0] = rx0_r;
  assign cry[0] = ry0_r;
  assign cqx[0] = '0;
  assign cqy[0] = '0;
  assign div_adv = cadv[0];
  assign cadv[COORD_BITS] = out_adv;

  for (genvar i = 0; i < COORD_BITS; i++) begin : g_cell
    trl_cell #(.COORD_BITS(COORD_BITS), .SHIFT(COORD_BITS - 1 - i)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(cv[i]), .adv_o(cadv[i]), .adv_i(cadv[i+1]),
      .side_i(cs[i]), .rx_i(crx[i]), .ry_i(cry[i]), .qx_i(cqx[i]), .qy_i(cqy[i]),
      .dmag(cfg.dmag),
      .vld_o(cv[i+1]), .side_o(cs[i+1]), .rx_o(crx[i+1]), .ry_o(cry[i+1]),
      .qx_o(cqx[i+1]), .qy_o(cqy[i+1])
    );
  end

  // Output stage: apply sign, saturate, gate on solvability
  localparam logic [COORD_BITS-1:0] HI   = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] LO   = {1'b1, {(COORD_BITS-1){1'b0}}};

  trl_pkg::side_t        sf;
  logic [COORD_BITS-1:0] qx, qy, px_nxt, py_nxt;
  logic                  clx, cly;
  logic                  ov_r, solved_r, clipped_r;
  logic [COORD_BITS-1:0] px_r, py_r;

  always_comb begin
    sf = cs[COORD_BITS];
    qx = cqx[COORD_BITS];
    qy = cqy[COORD_BITS];
    clx = 1'b0;
    cly = 1'b0;
    if (sf.ovf_x) begin
      clx = 1'b1;  px_nxt = sf.neg_x ? LO : HI;
    end else if (!sf.neg_x) begin
      clx = qx[COORD_BITS-1];  px_nxt = clx ? HI : qx;
    end else begin
      clx = qx > LO;  px_nxt = clx ? LO : -qx;
    end
    if (sf.ovf_y) begin
      cly = 1'b1;  py_nxt = sf.neg_y ? LO : HI;
    end else if (!sf.neg_y) begin
      cly = qy[COORD_BITS-1];  py_nxt = cly ? HI : qy;
    end else begin
      cly = qy > LO;  py_nxt = cly ? LO : -qy;
    end
    if (!sf.solved) begin
      px_nxt = '0;  py_nxt = '0;  clx = 1'b0;  cly = 1'b0;
    end
  end

  assign out_adv = !ov_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_adv) begin
      ov_r <= cv[COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && cv[COORD_BITS]) begin
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      solved_r  <= sf.solved;
      clipped_r <= clx || cly;
    end
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.pos_x   = px_r;
  assign out_ch.pos_y   = py_r;
  assign out_ch.solved  = solved_r;
  assign out_ch.clipped = clipped_r;

  // Unsolved results carry zero coordinates and no clip flag
  a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.solved |-> out_ch.pos_x == '0 && out_ch.pos_y == '0
      && !out_ch.clipped)
    else $error("unsolved result not zeroed");

  // Clipping only happens on solved results
  a_clip_solved: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.clipped |-> out_ch.solved)
    else $error("clip flag without solution");

  // Input only backs up when the whole pipeline is full behind a stalled output
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without output stall");

endmodule

>>> sim/trl_tb_pkg.sv
`timescale 1ns / 100ps
package trl_tb_pkg;

  // Position estimate as the block should report it
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               solved;
    logic               clipped;
  } fix_t;

endpackage

>>> sim/testbench.sv
`timescale 1ns / 100ps
module testbench;

  localparam int LAT = 16 + 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [trl_pkg::ADDR_W-1:0] paddr = '0;
  logic [trl_pkg::DATA_W-1:0] pwdata = '0;
  logic [trl_pkg::DATA_W-1:0] prdata;
  logic pready;

  trl_in_if in_ch ();
  trl_out_if #(.COORD_BITS(16)) out_ch ();

  three_anchor_trilateration #(.COORD_BITS(16)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Anchor setup held by the testbench
  logic signed [15:0] anc_ax, anc_ay, anc_bx, anc_by, anc_cx, anc_cy;
  logic [31:0] min_det;

  trl_tb_pkg::fix_t expected_fixes[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.range_a = '0;
    in_ch.range_b = '0;
    in_ch.range_c = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic signed [63:0] clamp16(input logic signed [63:0] v, inout logic clip);
    if (v > 64'sd32767) begin
      clip = 1'b1;
      return 64'sd32767;
    end
    if (v < -64'sd32768) begin
      clip = 1'b1;
      return -64'sd32768;
    end
    return v;
  endfunction

  // Solve the two circle-difference equations by Cramer's rule
  function automatic trl_tb_pkg::fix_t locate(input logic [15:0] ra_i, rb_i, rc_i);
    logic signed [63:0] ax, ay, bx, by, cx, cy, ra, rb, rc;
    logic signed [63:0] a1, b1, c1, a2, b2, c2, det, mag, nx, ny, qx, qy;
    logic clip;
    trl_tb_pkg::fix_t f;
    ax = anc_ax; ay = anc_ay; bx = anc_bx; by = anc_by; cx = anc_cx; cy = anc_cy;
    ra = {48'd0, ra_i}; rb = {48'd0, rb_i}; rc = {48'd0, rc_i};
    a1 = 2 * (bx - ax);
    b1 = 2 * (by - ay);
    c1 = ra * ra - rb * rb - ax * ax + bx * bx - ay * ay + by * by;
    a2 = 2 * (cx - bx);
    b2 = 2 * (cy - by);
    c2 = rb * rb - rc * rc - bx * bx + cx * cx - by * by + cy * cy;
    det = a1 * b2 - b1 * a2;
    mag = det < 0 ? -det : det;
    f = '0;
    clip = 1'b0;
    if (det != 0 && mag >= $signed({32'd0, min_det})) begin
      nx = c1 * b2 - c2 * b1;
      ny = a1 * c2 - a2 * c1;
      qx = clamp16(nx / det, clip);
      qy = clamp16(ny / det, clip);
      f.pos_x = qx[15:0];
      f.pos_y = qy[15:0];
      f.solved = 1'b1;
      f.clipped = clip;
    end
    return f;
  endfunction

  // Write one register through setup and access cycles
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= trl_pkg::ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      trl_pkg::REG_AX: anc_ax = val[15:0];
      trl_pkg::REG_AY: anc_ay = val[15:0];
      trl_pkg::REG_BX: anc_bx = val[15:0];
      trl_pkg::REG_BY: anc_by = val[15:0];
      trl_pkg::REG_CX: anc_cx = val[15:0];
      trl_pkg::REG_CY: anc_cy = val[15:0];
      trl_pkg::REG_MIN: min_det = val;
      default: ;
    endcase
  endtask

  task automatic set_anchors(input logic signed [15:0] ax, ay, bx, by, cx, cy,
                             input logic [31:0] md);
    write_reg(trl_pkg::REG_AX, 32'(ax));
    write_reg(trl_pkg::REG_AY, 32'(ay));
    write_reg(trl_pkg::REG_BX, 32'(bx));
    write_reg(trl_pkg::REG_BY, 32'(by));
    write_reg(trl_pkg::REG_CX, 32'(cx));
    write_reg(trl_pkg::REG_CY, 32'(cy));
    write_reg(trl_pkg::REG_MIN, md);
    repeat (6) @(posedge clk);
  endtask

  // Offer one range triple and hold it until accepted
  task automatic send_ranges(input logic [15:0] ra, rb, rc);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.range_a <= ra;
    in_ch.range_b <= rb;
    in_ch.range_c <= rc;
    do @(posedge clk); while (!in_ch.ready);
    expected_fixes.push_back(locate(ra, rb, rc));
  endtask

  // Drop valid and wait for every outstanding transaction to return
  task automatic drain();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (expected_fixes.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LAT + 4) @(posedge clk);
  endtask

  // Receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    trl_tb_pkg::fix_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_fixes.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, out_ch.pos_x, out_ch.pos_y);
        errors++;
      end else begin
        want = expected_fixes.pop_front();
        if (out_ch.pos_x !== want.pos_x || out_ch.pos_y !== want.pos_y ||
            out_ch.solved !== want.solved || out_ch.clipped !== want.clipped) begin
          $display("%0t: expected x=%0d y=%0d s=%0b c=%0b, got x=%0d y=%0d s=%0b c=%0b",
                   $time, want.pos_x, want.pos_y, want.solved, want.clipped,
                   out_ch.pos_x, out_ch.pos_y, out_ch.solved, out_ch.clipped);
          errors++;
        end
      end
    end
  end

  logic [15:0] ra_r, rb_r, rc_r;

  // Ranges from a true point plus small noise, so most triples are consistent
  task automatic send_near_point();
    int px, py;
    px = $signed($urandom_range(4000)) - 2000;
    py = $signed($urandom_range(4000)) - 2000;
    ra_r = 16'($rtoi($sqrt(real'((px - anc_ax) ** 2 + (py - anc_ay) ** 2))) +
               $urandom_range(3));
    rb_r = 16'($rtoi($sqrt(real'((px - anc_bx) ** 2 + (py - anc_by) ** 2))) +
               $urandom_range(3));
    rc_r = 16'($rtoi($sqrt(real'((px - anc_cx) ** 2 + (py - anc_cy) ** 2))) +
               $urandom_range(3));
    send_ranges(ra_r, rb_r, rc_r);
  endtask

  task automatic send_random(input int n);
    repeat (n) begin
      if ($urandom_range(3) == 0)
        send_ranges(16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_near_point();
    end
  endtask

  task automatic test_reset_anchors();
    anc_ax = -16'sd90; anc_ay = 0; anc_bx = 16'sd90; anc_by = 0;
    anc_cx = 0; anc_cy = 16'sd450; min_det = 32'd1;
    send_ranges(16'd0, 16'd0, 16'd0);
    send_ranges(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_ranges(16'hFFFF, 16'd0, 16'd0);
    send_ranges(16'd0, 16'hFFFF, 16'd0);
    send_ranges(16'd0, 16'd0, 16'hFFFF);
    send_ranges(16'd90, 16'd90, 16'd450);
    send_ranges(16'd127, 16'd127, 16'd318);
    drain();
  endtask

  task automatic test_degenerate();
    // collinear anchors: zero determinant, even with a zero minimum
    set_anchors(-16'sd100, 0, 0, 0, 16'sd100, 0, 32'd0);
    send_ranges(16'd100, 16'd10, 16'd100);
    send_ranges(16'd5, 16'd300, 16'd7);
    drain();
    // determinant below the minimum, then at the largest minimum
    set_anchors(0, 0, 16'sd1, 0, 0, 16'sd1, 32'd5);
    send_ranges(16'd1, 16'd1, 16'd1);
    drain();
    set_anchors(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, 0, 16'sd32767,
                32'hFFFFFFFF);
    send_ranges(16'd1000, 16'd2000, 16'd3000);
    drain();
  endtask

  task automatic test_clipping();
    // tiny anchor spread drives quotients out of 16 bits
    set_anchors(0, 0, 16'sd1, 0, 0, 16'sd1, 32'd0);
    send_ranges(16'hFFFF, 16'd0, 16'd0);
    send_ranges(16'd0, 16'hFFFF, 16'd0);
    send_ranges(16'd0, 16'd0, 16'hFFFF);
    send_ranges(16'hFFFF, 16'hFFFF, 16'd0);
    drain();
    set_anchors(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, 0, 16'sd32767, 32'd0);
    send_ranges(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_ranges(16'd0, 16'hFFFF, 16'd0);
    drain();
  endtask

  task automatic test_random_setups();
    for (int k = 0; k < 6; k++) begin
      set_anchors(16'($urandom_range(6000)) - 16'sd3000, 16'($urandom_range(6000)) - 16'sd3000,
                  16'($urandom_range(6000)) - 16'sd3000, 16'($urandom_range(6000)) - 16'sd3000,
                  16'($urandom_range(6000)) - 16'sd3000, 16'($urandom),
                  (k == 5) ? 32'($urandom) : 32'($urandom_range(1000)));
      send_idle_pct = (k % 4 == 1 || k % 4 == 3) ? (k % 4 == 3 ? 11 : 64) : 0;
      recv_stall_pct = (k % 4 == 2 || k % 4 == 3) ? (k % 4 == 3 ? 11 : 64) : 0;
      send_random(180);
      drain();
    end
  endtask

  task automatic test_idle_phases();
    set_anchors(-16'sd90, 0, 16'sd90, 0, 0, 16'sd450, 32'd1);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 11 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 11 : 0;
      send_random(120);
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_off <= 200;
    send_random(150);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_anchors();
    test_degenerate();
    test_clipping();
    test_idle_phases();
    test_backpressure();
    test_random_setups();
    drain();
    if (errors == 0 && expected_fixes.size() == 0)
      $display("three_anchor_trilateration regression: pass");
    else
      $display("three_anchor_trilateration regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("three_anchor_trilateration regression: fail");
    $finish;
  end

endmodule
